FILE: rtl/chsi_pkg.sv
// Package for the chained hash site index unit.
// Holds operation codes, controller states, the site entry type and the hash.
// No dependencies.
package chsi_pkg;

  localparam int unsigned MaxSites   = 1024;
  localparam int unsigned SiteBits   = $clog2(MaxSites);
  localparam int unsigned CountBits  = SiteBits + 1;
  localparam int unsigned MinBuckets = 64;
  localparam logic [31:0] HashMult   = 32'h9E37_79B1;

  localparam logic [CountBits-1:0] NoSite = {CountBits{1'b1}};

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_REBUILD    = 3'd1,
    OP_ENSURE     = 3'd2,
    OP_INVALIDATE = 3'd3,
    OP_LOOKUP     = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_RB_RD,
    ST_RB_HASH,
    ST_RB_HRD,
    ST_RB_WR,
    ST_LK_HASH,
    ST_LK_HRD,
    ST_LK_HD,
    ST_LK_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CountBits-1:0] link;
    logic [31:0]          key;
  } site_ent_t;

  // Low bits of the product depend only on the low bits of both factors.
  function automatic logic [SiteBits-1:0] bucket_hash(input logic [31:0] key);
    logic [2*SiteBits-1:0] prod;
    prod = key[SiteBits-1:0] * HashMult[SiteBits-1:0];
    return prod[SiteBits-1:0];
  endfunction

endpackage

FILE: rtl/chained_hash_site_index_unit.sv
// Top level of the chained hash site index unit: site list, bucket heads, controller.
// Depends on chsi_pkg.
//
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_op, in_key
// out      output     out_valid, out_ready, out_usable, out_found, out_site_idx,
//                     out_rejected
//
// Append, invalidate, ensure without work, unusable lookups and unknown operations
// go straight from idle to the done state.
// A usable lookup hashes the key, reads the bucket head, then visits each chain entry in turn.
// A rebuild runs the head clear sweep over every bucket, then the serial
// read-modify-write of one site at a time.
// Reset is synchronous; no memory clearing pass is needed after it.
// A new beat is taken while a finished result still waits at the output.
module chained_hash_site_index_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_op,
  input  logic [31:0]                    in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_usable,
  output logic                           out_found,
  output logic [chsi_pkg::SiteBits-1:0]  out_site_idx,
  output logic                           out_rejected
);

  localparam int unsigned SB = chsi_pkg::SiteBits;
  localparam int unsigned CB = chsi_pkg::CountBits;

  chsi_pkg::site_ent_t site_mem [chsi_pkg::MaxSites];
  logic [CB-1:0]       head_mem [chsi_pkg::MaxSites];

  chsi_pkg::state_t state_r, state_nxt;
  logic [CB-1:0] site_total_r, site_total_nxt;
  logic [CB-1:0] indexed_r, indexed_nxt;
  logic          present_r, present_nxt;
  logic [SB-1:0] mask_r, mask_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] cand_r, cand_nxt;
  logic [SB-1:0] bucket_r, bucket_nxt;
  logic [31:0]   key_r, key_nxt;
  logic          res_usable_r, res_usable_nxt;
  logic          res_found_r, res_found_nxt;
  logic [SB-1:0] res_idx_r, res_idx_nxt;
  logic          res_rej_r, res_rej_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_usable_r, out_found_r, out_rej_r;
  logic [SB-1:0] out_idx_r;
  logic          out_load;

  chsi_pkg::site_ent_t site_rd_r, site_wd;
  logic [SB-1:0]       site_ra, site_wa;
  logic                site_we;
  logic [CB-1:0]       head_rd_r, head_wd;
  logic [SB-1:0]       head_ra, head_wa;
  logic                head_we;

  logic [SB-1:0] smear;
  logic [SB-1:0] new_mask;
  logic          accept;

  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[site_wa] <= site_wd;
    end
    site_rd_r <= site_mem[site_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_r <= head_mem[head_ra];
  end

  always_comb begin
    smear = (site_total_r == '0) ? '0 : SB'(site_total_r - CB'(1));
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    new_mask = smear | SB'(chsi_pkg::MinBuckets - 1);
  end

  assign in_ready  = (state_r == chsi_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == chsi_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    site_total_nxt = site_total_r;
    indexed_nxt    = indexed_r;
    present_nxt    = present_r;
    mask_nxt       = mask_r;
    cnt_nxt        = cnt_r;
    cand_nxt       = cand_r;
    bucket_nxt     = bucket_r;
    key_nxt        = key_r;
    res_usable_nxt = res_usable_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    res_rej_nxt    = res_rej_r;
    site_ra        = cnt_r[SB-1:0];
    site_wa        = site_total_r[SB-1:0];
    site_wd        = '{link: chsi_pkg::NoSite, key: in_key};
    site_we        = 1'b0;
    head_ra        = bucket_r;
    head_wa        = cnt_r[SB-1:0];
    head_wd        = chsi_pkg::NoSite;
    head_we        = 1'b0;

    unique case (state_r)
      chsi_pkg::ST_IDLE: begin
        if (accept) begin
          res_usable_nxt = 1'b0;
          res_found_nxt  = 1'b0;
          res_idx_nxt    = '0;
          res_rej_nxt    = 1'b0;
          key_nxt        = in_key;
          cnt_nxt        = '0;
          state_nxt      = chsi_pkg::ST_DONE;
          unique case (in_op)
            chsi_pkg::OP_APPEND: begin
              if (site_total_r < CB'(chsi_pkg::MaxSites)) begin
                site_we        = 1'b1;
                site_total_nxt = site_total_r + CB'(1);
              end else begin
                res_rej_nxt = 1'b1;
              end
            end
            chsi_pkg::OP_REBUILD: begin
              mask_nxt  = new_mask;
              state_nxt = chsi_pkg::ST_CLR;
            end
            chsi_pkg::OP_ENSURE: begin
              if (indexed_r != site_total_r) begin
                mask_nxt  = new_mask;
                state_nxt = chsi_pkg::ST_CLR;
              end
            end
            chsi_pkg::OP_INVALIDATE: begin
              indexed_nxt = '0;
              present_nxt = 1'b0;
            end
            chsi_pkg::OP_LOOKUP: begin
              if (present_r && (indexed_r == site_total_r)) begin
                res_usable_nxt = 1'b1;
                state_nxt      = chsi_pkg::ST_LK_HASH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      chsi_pkg::ST_CLR: begin
        head_we = 1'b1;
        if (cnt_r[SB-1:0] == mask_r) begin
          cnt_nxt = '0;
          if (site_total_r == '0) begin
            indexed_nxt = site_total_r;
            present_nxt = 1'b1;
            state_nxt   = chsi_pkg::ST_DONE;
          end else begin
            state_nxt = chsi_pkg::ST_RB_RD;
          end
        end else begin
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      chsi_pkg::ST_RB_RD: begin
        state_nxt = chsi_pkg::ST_RB_HASH;
      end
      chsi_pkg::ST_RB_HASH: begin
        key_nxt    = site_rd_r.key;
        bucket_nxt = chsi_pkg::bucket_hash(site_rd_r.key) & mask_r;
        state_nxt  = chsi_pkg::ST_RB_HRD;
      end
      chsi_pkg::ST_RB_HRD: begin
        state_nxt = chsi_pkg::ST_RB_WR;
      end
      chsi_pkg::ST_RB_WR: begin
        site_we = 1'b1;
        site_wa = cnt_r[SB-1:0];
        site_wd = '{link: head_rd_r, key: key_r};
        head_we = 1'b1;
        head_wa = bucket_r;
        head_wd = cnt_r;
        cnt_nxt = cnt_r + CB'(1);
        if (cnt_r + CB'(1) == site_total_r) begin
          indexed_nxt = site_total_r;
          present_nxt = 1'b1;
          state_nxt   = chsi_pkg::ST_DONE;
        end else begin
          state_nxt = chsi_pkg::ST_RB_RD;
        end
      end
      chsi_pkg::ST_LK_HASH: begin
        bucket_nxt = chsi_pkg::bucket_hash(key_r) & mask_r;
        state_nxt  = chsi_pkg::ST_LK_HRD;
      end
      chsi_pkg::ST_LK_HRD: begin
        state_nxt = chsi_pkg::ST_LK_HD;
      end
      chsi_pkg::ST_LK_HD: begin
        site_ra  = head_rd_r[SB-1:0];
        cand_nxt = head_rd_r;
        if (head_rd_r == chsi_pkg::NoSite || head_rd_r >= indexed_r) begin
          state_nxt = chsi_pkg::ST_DONE;
        end else begin
          state_nxt = chsi_pkg::ST_LK_CMP;
        end
      end
      chsi_pkg::ST_LK_CMP: begin
        if (site_rd_r.key == key_r) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = cand_r[SB-1:0];
        end
        site_ra  = site_rd_r.link[SB-1:0];
        cand_nxt = site_rd_r.link;
        if (site_rd_r.link == chsi_pkg::NoSite || site_rd_r.link >= indexed_r) begin
          state_nxt = chsi_pkg::ST_DONE;
        end
      end
      chsi_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = chsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chsi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= chsi_pkg::ST_IDLE;
      site_total_r <= '0;
      indexed_r    <= '0;
      present_r    <= 1'b0;
      mask_r       <= SB'(chsi_pkg::MinBuckets - 1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      site_total_r <= site_total_nxt;
      indexed_r    <= indexed_nxt;
      present_r    <= present_nxt;
      mask_r       <= mask_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    cand_r       <= cand_nxt;
    bucket_r     <= bucket_nxt;
    key_r        <= key_nxt;
    res_usable_r <= res_usable_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
    res_rej_r    <= res_rej_nxt;
    if (out_load) begin
      out_usable_r <= res_usable_r;
      out_found_r  <= res_found_r;
      out_idx_r    <= res_idx_r;
      out_rej_r    <= res_rej_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_usable     = out_usable_r;
  assign out_found      = out_found_r;
  assign out_site_idx   = out_idx_r;
  assign out_rejected   = out_rej_r;

`ifndef NO_ASSERTIONS
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    present_r |-> (indexed_r <= site_total_r))
    else $error("index present with indexed count above site count");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (site_total_r == CB'(chsi_pkg::MaxSites)))
    else $error("append rejected while site list not full");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chsi_pkg::ST_LK_CMP) |-> (cand_r < indexed_r))
    else $error("chain walk outside indexed sites");
`endif

endmodule
